>>> design/nps_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package nps_pkg;

	// Default configuration
	localparam int POINT_CAPACITY_DEF = 256;
	localparam int COORD_BITS_DEF     = 24;

	// Fixed widths of the ports
	localparam int REQ_W  = 2;
	localparam int IDX_W  = 8;
	localparam int DIST_W = 50;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_NEW    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic write_first;
		logic write_append;
		logic query_load;
		logic scan_issue;
		logic result_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic set_empty;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

>>> design/nps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nps_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/nps_ctrl.sv
// Controller state machine: word acceptance, scan sequencing and result hand-off.
module nps_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [nps_pkg::REQ_W-1:0] req_type,
	input  nps_pkg::dp_status_t       status,
	output nps_pkg::ctrl_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode the state into commands and the next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						nps_pkg::REQ_NEW:    cmd.write_first  = 1'b1;
						nps_pkg::REQ_APPEND: cmd.write_append = 1'b1;
						nps_pkg::REQ_QUERY: begin
							cmd.query_load = 1'b1;
							state_d = status.set_empty ? ST_RESULT : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/nps_datapath.sv
// Datapath: point store, distance pipeline, running minimum and output register.
module nps_datapath #(
	parameter int POINT_CAPACITY = nps_pkg::POINT_CAPACITY_DEF,
	parameter int COORD_BITS     = nps_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nps_pkg::ctrl_cmd_t                cmd,
	output nps_pkg::dp_status_t               status,
	input  logic signed [COORD_BITS-1:0]      coord_x,
	input  logic signed [COORD_BITS-1:0]      coord_y,
	input  logic signed [COORD_BITS-1:0]      coord_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              match_found,
	output logic [nps_pkg::IDX_W-1:0]         match_index,
	output logic [nps_pkg::DIST_W-1:0]        match_distance_sq,
	output logic                              set_overflow
);

	localparam int IW = (POINT_CAPACITY > 1) ? $clog2(POINT_CAPACITY) : 1;
	localparam int CW = $clog2(POINT_CAPACITY + 1);
	localparam int SW = 2 * COORD_BITS;
	localparam int DW = 2 * COORD_BITS + 2;
	localparam int PW = 3 * COORD_BITS;

	// Set bookkeeping
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          set_full;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;

	assign set_full  = (count_q == CW'(POINT_CAPACITY));
	assign ram_we    = cmd.write_first || (cmd.write_append && !set_full);
	assign ram_waddr = cmd.write_first ? '0 : count_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.write_first) begin
			count_q <= CW'(1);
			ovf_q   <= 1'b0;
		end else if (cmd.write_append) begin
			if (set_full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Point store
	logic [PW-1:0] rdata;
	logic [IW-1:0] scan_q;

	nps_ram #(
		.WIDTH (PW),
		.DEPTH (POINT_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({coord_x, coord_y, coord_z}),
		.re    (cmd.scan_issue),
		.raddr (scan_q),
		.rdata (rdata)
	);

	// Hold the query point and step the scan address
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;
	logic signed [COORD_BITS-1:0] qz_q;

	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
			qz_q <= coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.query_load) begin
			scan_q <= '0;
		end else if (cmd.scan_issue) begin
			scan_q <= scan_q + IW'(1);
		end
	end

	// Stage valid flags
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: read data arrives with its index
	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [COORD_BITS-1:0] rx, ry, rz;

	assign rx = rdata[PW-1 -: COORD_BITS];
	assign ry = rdata[SW-1 -: COORD_BITS];
	assign rz = rdata[COORD_BITS-1:0];

	// Stage 2: absolute coordinate differences
	logic signed [COORD_BITS:0] dx, dy, dz;
	logic [COORD_BITS-1:0] ax_s2, ay_s2, az_s2;

	assign dx = (COORD_BITS+1)'(qx_q) - (COORD_BITS+1)'(rx);
	assign dy = (COORD_BITS+1)'(qy_q) - (COORD_BITS+1)'(ry);
	assign dz = (COORD_BITS+1)'(qz_q) - (COORD_BITS+1)'(rz);

	// Stage 3: squares; stage 4: sum
	logic [SW-1:0] sx_s3, sy_s3, sz_s3;
	logic [DW-1:0] sum_s4;

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		ax_s2  <= COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
		ay_s2  <= COORD_BITS'(dy[COORD_BITS] ? -dy : dy);
		az_s2  <= COORD_BITS'(dz[COORD_BITS] ? -dz : dz);
		sx_s3  <= SW'(ax_s2) * SW'(ax_s2);
		sy_s3  <= SW'(ay_s2) * SW'(ay_s2);
		sz_s3  <= SW'(az_s2) * SW'(az_s2);
		sum_s4 <= DW'(sx_s3) + DW'(sy_s3) + DW'(sz_s3);
	end

	// Keep the running minimum, earliest point on a tie
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [DW-1:0] best_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.query_load) begin
			found_q <= 1'b0;
		end else if (v_s4) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_load) begin
			best_idx_q  <= '0;
			best_dist_q <= '0;
		end else if (v_s4 && (!found_q || (sum_s4 < best_dist_q))) begin
			best_idx_q  <= idx_s4;
			best_dist_q <= sum_s4;
		end
	end

	// Output register: load a result word, drop it once taken
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			match_found       <= found_q;
			match_index       <= nps_pkg::IDX_W'(best_idx_q);
			match_distance_sq <= nps_pkg::DIST_W'(best_dist_q);
			set_overflow      <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller
	assign status.set_empty = (count_q == '0);
	assign status.scan_last = (CW'(scan_q) == (count_q - CW'(1)));
	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

>>> design/nearest_point_search.sv
// Top level of the brute-force 3D nearest reference point search.
// Load words (start a new set, append a point) keep the block ready for the next word;
// a full set drops further points and raises a sticky overflow flag until a new set
// starts. A query word scans the N stored points (N up to POINT_CAPACITY) and then
// loads a result word: the single read port of the point store delivers one point
// per cycle to a four-stage distance pipeline (difference, square, sum, compare),
// which then drains. A query on an empty set skips the scan and loads its result
// word, with no match, once the output register is free. Input is taken only
// between queries; a finished result waits in an output register while the next
// load words are taken. The store needs no clearing pass.
module nearest_point_search #(
	parameter int POINT_CAPACITY = nps_pkg::POINT_CAPACITY_DEF,
	parameter int COORD_BITS     = nps_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nps_pkg::REQ_W-1:0]    req_type,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         match_found,
	output logic [nps_pkg::IDX_W-1:0]    match_index,
	output logic [nps_pkg::DIST_W-1:0]   match_distance_sq,
	output logic                         set_overflow
);

	nps_pkg::ctrl_cmd_t  cmd;
	nps_pkg::dp_status_t status;

	// Sequence words and scans
	nps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd)
	);

	// Store points and compute distances
	nps_datapath #(
		.POINT_CAPACITY (POINT_CAPACITY),
		.COORD_BITS     (COORD_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.coord_x           (coord_x),
		.coord_y           (coord_y),
		.coord_z           (coord_z),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.match_found       (match_found),
		.match_index       (match_index),
		.match_distance_sq (match_distance_sq),
		.set_overflow      (set_overflow)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the nearest reference point search block.
`timescale 1ns / 1ps

module tb;

	localparam int CW  = nps_pkg::COORD_BITS_DEF;
	localparam int CAP = nps_pkg::POINT_CAPACITY_DEF;

	localparam logic [nps_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [CW-1:0] C_MAX  = 24'h7FFFFF;
	localparam logic [CW-1:0] C_MIN  = 24'h800000;
	localparam logic [CW-1:0] C_NEG1 = 24'hFFFFFF;

	localparam int ITEM_TARGET = 1200;
	localparam int CALM_TAIL   = 150;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 16;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic                       found;
		logic [nps_pkg::IDX_W-1:0]  idx;
		logic [nps_pkg::DIST_W-1:0] dist_sq;
		logic                       ovf;
	} match_t;

	typedef struct packed {
		logic [nps_pkg::REQ_W-1:0] req;
		logic [CW-1:0]             x;
		logic [CW-1:0]             y;
		logic [CW-1:0]             z;
		logic                      typed;
		match_t                    res;
	} probe_t;

	localparam match_t NO_MATCH = '{1'b0, 8'd0, 50'd0, 1'b0};

	// Directed words; typed results only where they follow at a glance
	localparam probe_t PROBES [20] = '{
		'{nps_pkg::REQ_QUERY,  24'h000000, 24'h000000, 24'h000000, 1'b1, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  C_MAX,      C_MIN,      C_NEG1,     1'b1, NO_MATCH},
		'{REQ_UNUSED,          24'h000001, 24'h000002, 24'h000003, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_NEW,    C_MAX,      C_MAX,      C_MAX,      1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  C_MIN,      C_MIN,      C_MIN,      1'b1,
			'{1'b1, 8'd0, 50'd844424829468675, 1'b0}},
		'{nps_pkg::REQ_APPEND, 24'h000000, 24'h000000, 24'h000000, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_APPEND, 24'h000000, 24'h000000, 24'h000000, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  24'h000000, 24'h000000, 24'h000000, 1'b1,
			'{1'b1, 8'd1, 50'd0, 1'b0}},
		'{nps_pkg::REQ_APPEND, C_MIN,      C_MIN,      C_MIN,      1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  C_MIN,      C_MIN,      C_MIN,      1'b1,
			'{1'b1, 8'd3, 50'd0, 1'b0}},
		'{REQ_UNUSED,          C_MIN,      C_MAX,      24'h000000, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  24'h000001, C_NEG1,     24'h000001, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_NEW,    C_NEG1,     C_NEG1,     C_NEG1,     1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  C_MAX,      C_MAX,      C_MAX,      1'b1,
			'{1'b1, 8'd0, 50'd211106232532992, 1'b0}},
		'{nps_pkg::REQ_APPEND, 24'h000123, 24'hFFF000, 24'h7FF000, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_APPEND, 24'h345678, 24'hCBA988, 24'h0F0F0F, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  24'h345677, 24'hCBA988, 24'h0F0F10, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  24'h555555, 24'hAAAAAA, 24'h000001, 1'b0, NO_MATCH},
		'{nps_pkg::REQ_APPEND, C_NEG1,     C_NEG1,     C_NEG1,     1'b0, NO_MATCH},
		'{nps_pkg::REQ_QUERY,  C_NEG1,     C_NEG1,     C_NEG1,     1'b1,
			'{1'b1, 8'd0, 50'd0, 1'b0}}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [nps_pkg::REQ_W-1:0]  req_type;
	logic signed [CW-1:0]       coord_x;
	logic signed [CW-1:0]       coord_y;
	logic signed [CW-1:0]       coord_z;
	logic                       out_valid;
	logic                       out_ready;
	logic                       match_found;
	logic [nps_pkg::IDX_W-1:0]  match_index;
	logic [nps_pkg::DIST_W-1:0] match_distance_sq;
	logic                       set_overflow;

	// Own copy of the point store
	logic signed [CW-1:0]  pt_x [CAP];
	logic signed [CW-1:0]  pt_y [CAP];
	logic signed [CW-1:0]  pt_z [CAP];
	int                    pt_count;
	logic                  pt_dropped;

	match_t                pending_matches [$];
	bit                    calm;
	int                    words_in;
	int                    sent;
	int                    deepest;
	int                    matches_seen;
	int                    overflow_seen;
	int                    mismatches;

	nearest_point_search u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.coord_z          (coord_z),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.match_found      (match_found),
		.match_index      (match_index),
		.match_distance_sq(match_distance_sq),
		.set_overflow     (set_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned sq_span(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		longint diff;
		diff = longint'(a) - longint'(b);
		return longint'(diff * diff);
	endfunction

	// Scan the stored set; a strict less-than keeps the earliest point on a tie
	function automatic match_t nearest_lookup(input logic signed [CW-1:0] qx,
		input logic signed [CW-1:0] qy, input logic signed [CW-1:0] qz);
		match_t            best;
		longint unsigned   d;
		best = NO_MATCH;
		best.ovf = pt_dropped;
		for (int i = 0; i < pt_count; i++) begin
			d = sq_span(qx, pt_x[i]) + sq_span(qy, pt_y[i]) + sq_span(qz, pt_z[i]);
			if (!best.found || d < best.dist_sq) begin
				best.found   = 1'b1;
				best.idx     = nps_pkg::IDX_W'(i);
				best.dist_sq = nps_pkg::DIST_W'(d);
			end
		end
		return best;
	endfunction

	function automatic logic signed [CW-1:0] pick_coord();
		int r;
		int v;
		r = $urandom_range(0, 9);
		v = $urandom_range(0, 8);
		if (r == 0) return C_MIN;
		if (r == 1) return C_MAX;
		if (r < 5) return CW'(v - 4);
		return CW'($urandom);
	endfunction

	function automatic int nudge();
		int v;
		v = $urandom_range(0, 4);
		if ($urandom_range(0, 1) == 0) return 0;
		return v - 2;
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) return $urandom_range(1, 8);
		if (r < 19) return $urandom_range(9, 64);
		return $urandom_range(200, CAP);
	endfunction

	// Offer one word, wait for the handshake, then update the predicted state
	task automatic push_word(input logic [nps_pkg::REQ_W-1:0] req,
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
		input logic typed = 1'b0, input match_t typed_res = NO_MATCH);
		match_t res;
		int     gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		coord_x  <= x;
		coord_y  <= y;
		coord_z  <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_in++;
		if (req != REQ_UNUSED) sent++;
		case (req)
			nps_pkg::REQ_NEW: begin
				pt_x[0] = x;
				pt_y[0] = y;
				pt_z[0] = z;
				pt_count = 1;
				pt_dropped = 1'b0;
			end
			nps_pkg::REQ_APPEND: begin
				if (pt_count < CAP) begin
					pt_x[pt_count] = x;
					pt_y[pt_count] = y;
					pt_z[pt_count] = z;
					pt_count++;
				end else begin
					pt_dropped = 1'b1;
				end
			end
			nps_pkg::REQ_QUERY: begin
				res = typed ? typed_res : nearest_lookup(x, y, z);
				pending_matches.insert(pending_matches.size(), res);
			end
			default: ;
		endcase
		if (pt_count > deepest) deepest = pt_count;
	endtask

	// Query mostly near a stored point to provoke close calls and ties
	task automatic query_word();
		int                   k;
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] qz;
		if (pt_count > 0 && $urandom_range(0, 9) < 6) begin
			k = $urandom_range(0, pt_count - 1);
			qx = pt_x[k] + CW'(nudge());
			qy = pt_y[k] + CW'(nudge());
			qz = pt_z[k] + CW'(nudge());
		end else begin
			qx = pick_coord();
			qy = pick_coord();
			qz = pick_coord();
		end
		push_word(nps_pkg::REQ_QUERY, qx, qy, qz);
	endtask

	// Build a set, with stray queries and unused codes mixed in, then query it
	task automatic run_episode(input bit fill);
		int n_pts;
		int n_q;
		n_pts = fill ? CAP + $urandom_range(1, 6) : pick_size();
		push_word(nps_pkg::REQ_NEW, pick_coord(), pick_coord(), pick_coord());
		for (int i = 1; i < n_pts; i++) begin
			if ($urandom_range(0, 15) == 0) query_word();
			if ($urandom_range(0, 19) == 0)
				push_word(REQ_UNUSED, CW'($urandom), CW'($urandom), CW'($urandom));
			push_word(nps_pkg::REQ_APPEND, pick_coord(), pick_coord(), pick_coord());
			if (sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
		end
		n_q = $urandom_range(1, 6);
		repeat (n_q) query_word();
	endtask

	task automatic check_match();
		match_t got;
		match_t want;
		got = '{match_found, match_index, match_distance_sq, set_overflow};
		matches_seen++;
		if (got.ovf) overflow_seen++;
		if (pending_matches.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("tb: result word with nothing expected: %s%0d idx=%0d dist=%0d ovf=%0d",
					"found=", got.found, got.idx, got.dist_sq, got.ovf);
			return;
		end
		want = pending_matches.pop_front();
		if (got.found !== want.found || got.idx !== want.idx ||
			got.dist_sq !== want.dist_sq || got.ovf !== want.ovf) begin
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("tb: result %0d: want found=%0d idx=%0d dist=%0d ovf=%0d",
					matches_seen, want.found, want.idx, want.dist_sq, want.ovf);
				$display("tb: result %0d: got  found=%0d idx=%0d dist=%0d ovf=%0d",
					matches_seen, got.found, got.idx, got.dist_sq, got.ovf);
			end
		end
	endtask

	// Result side: take words and stall in random bursts
	initial begin
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) check_match();
			if (stall > 0) stall--;
			else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
			out_ready <= (stall == 0);
		end
	end

	// Watchdog: end the run when no word moves for too long
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("tb: no word moved for %0d cycles", QUIET_LIMIT);
		$display("tb: FAIL");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int ep;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		req_type <= nps_pkg::REQ_NEW;
		coord_x  <= '0;
		coord_y  <= '0;
		coord_z  <= '0;
		pt_count = 0;
		pt_dropped = 1'b0;
		calm = 1'b0;
		words_in = 0;
		sent = 0;
		deepest = 0;
		matches_seen = 0;
		overflow_seen = 0;
		mismatches = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			push_word(PROBES[i].req, PROBES[i].x, PROBES[i].y, PROBES[i].z,
				PROBES[i].typed, PROBES[i].res);

		// Random sets; the second one always runs past capacity
		ep = 0;
		while (sent < ITEM_TARGET) begin
			run_episode(ep == 1 || $urandom_range(0, 24) == 0);
			ep++;
		end
		in_valid <= 1'b0;

		while (pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("tb: %0d words taken over %0d sets, %0d results checked",
			words_in, ep, matches_seen);
		$display("tb: largest set %0d points, %0d results reported dropped points",
			deepest, overflow_seen);
		if (mismatches == 0 && pending_matches.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/nps_pkg.sv
design/nps_ram.sv
design/nps_ctrl.sv
design/nps_datapath.sv
design/nearest_point_search.sv
tb/sv/tb.sv
